### src/stdp_su_pkg.sv
`timescale 1ns / 1ps
// Package for the STDP synapse update unit: types, codes and reset values.
// No dependencies.
package stdp_su_pkg;

  localparam int unsigned SynapsesDefault = 1024;

  typedef enum logic [1:0] {
    ACT_PRE  = 2'd0,
    ACT_POST = 2'd1,
    ACT_JUMP = 2'd2,
    ACT_LOAD = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_WEIGHT_MAX  = 3'd0,
    REG_DRIVE_GAIN  = 3'd1,
    REG_LEARN_RATE  = 3'd2,
    REG_POT_STEP    = 3'd3,
    REG_POT_WINDOW  = 3'd4,
    REG_DEP_STEP    = 3'd5,
    REG_DEP_WINDOW  = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_FIN
  } state_t;

  localparam logic signed [15:0] WeightMaxReset = 16'sd4096;
  localparam logic [15:0]        DriveGainReset = 16'd4096;
  localparam logic [12:0]        StepReset      = 13'd410;
  localparam logic [31:0]        WindowReset    = 32'd20000;

  // Quotient bits produced by the divider and bits retired per cycle.
  localparam int unsigned QuoBits  = 26;
  localparam int unsigned DivRadix = 2;
  localparam int unsigned DivSteps = QuoBits / DivRadix;

endpackage

### src/stdp_synapse_update_unit.sv
`timescale 1ns / 1ps
// STDP synapse update unit: weight and spike-time tables with a window learning rule.
// Depends on stdp_su_pkg.
//
// Each word passes through the states READ, MUL, DIV, APPLY and FIN. The tables are
// read at the accepting edge. After that come the window set-up, the scale product,
// the shared radix-4 restoring divider that scales by the window length, and the
// weight update. One word is processed at a time. The next word can be accepted in
// the cycle after the result is registered. A finished result waits in the output
// register while the next word is accepted. The tables sit in two synchronous
// memories that are read at acceptance and written back in the final state for
// in-range words other than jumps. Entries that were never loaded return undefined data.
module stdp_synapse_update_unit
  import stdp_su_pkg::*;
#(
  parameter int unsigned SYNAPSES = SynapsesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // synapse[9:0], spike_time[41:10], post_last_spike[73:42], load_weight[89:74], zero pad
  input  logic [95:0] in_tdata,
  // action[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // potential_delta[31:0], new_weight[47:32]
  output logic [47:0] out_tdata
);

  localparam int unsigned AW = (SYNAPSES > 1) ? $clog2(SYNAPSES) : 1;

  // Configuration registers.
  logic signed [15:0] weight_max_r;
  logic [15:0] drive_gain_r;
  logic [12:0] learn_rate_r, pot_step_r, dep_step_r;
  logic [31:0] pot_window_r, dep_window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_max_r <= WeightMaxReset;
      drive_gain_r <= DriveGainReset;
      learn_rate_r <= StepReset;
      pot_step_r   <= StepReset;
      pot_window_r <= WindowReset;
      dep_step_r   <= StepReset;
      dep_window_r <= WindowReset;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_WEIGHT_MAX: weight_max_r <= $signed(cfg_data[15:0]);
        REG_DRIVE_GAIN: drive_gain_r <= cfg_data[15:0];
        REG_LEARN_RATE: learn_rate_r <= cfg_data[12:0];
        REG_POT_STEP:   pot_step_r   <= cfg_data[12:0];
        REG_POT_WINDOW: pot_window_r <= cfg_data;
        REG_DEP_STEP:   dep_step_r   <= cfg_data[12:0];
        REG_DEP_WINDOW: dep_window_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured word.
  action_t            action_r;
  logic [9:0]         synapse_r;
  logic [31:0]        spike_time_r, post_last_r;
  logic signed [15:0] load_weight_r;
  logic               in_range;

  // Tables.
  logic signed [15:0] weight_mem [SYNAPSES];
  logic [31:0]        time_mem   [SYNAPSES];
  logic signed [15:0] w_q;
  logic [31:0]        t_q;
  logic               accept;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_w, wr_t;
  logic signed [15:0] wr_w_data;

  assign accept  = in_tvalid && in_tready;
  assign rd_addr = AW'(in_tdata[9:0]);

  always_ff @(posedge clk) begin
    if (accept) begin
      w_q <= weight_mem[rd_addr];
      t_q <= time_mem[rd_addr];
    end
    if (wr_w) weight_mem[wr_addr] <= wr_w_data;
    if (wr_t) time_mem[wr_addr] <= spike_time_r;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_r      <= action_t'(in_tuser);
      synapse_r     <= in_tdata[9:0];
      spike_time_r  <= in_tdata[41:10];
      post_last_r   <= in_tdata[73:42];
      load_weight_r <= $signed(in_tdata[89:74]);
    end
  end

  assign in_range = {7'd0, synapse_r} < 17'(SYNAPSES);
  assign wr_addr  = AW'(synapse_r);

  // Datapath registers.
  state_t state_r, state_nxt;
  logic [3:0]  cnt_r;
  logic        learn_r;
  logic [31:0] n_r, win_r, rem_r;
  logic [25:0] num_r, quo_r;
  logic signed [31:0] delta_r;
  logic signed [43:0] prod2_r;
  logic        out_valid_r;
  logic [47:0] out_data_r;

  // Window set-up from the table read.
  logic is_pre;
  logic [31:0] dt, win_sel;
  logic [32:0] twice;
  logic [31:0] n_sel;
  logic signed [33:0] dprod;
  logic [57:0] prod;

  assign is_pre  = (action_r == ACT_PRE);
  assign dt      = is_pre ? (spike_time_r - post_last_r) : (spike_time_r - t_q);
  assign win_sel = is_pre ? dep_window_r : pot_window_r;
  assign twice   = {dt, 1'b0};

  always_comb begin
    if (is_pre) begin
      n_sel = win_sel - dt;
    end else if (twice <= {1'b0, win_sel}) begin
      n_sel = twice[31:0];
    end else begin
      n_sel = (win_sel - dt) << 1;
    end
  end

  assign dprod = 34'(w_q) * $signed({18'd0, drive_gain_r});
  assign prod  = 58'(num_r) * 58'(n_r);

  // Two restoring division steps a cycle; the remainder stays below the window.
  logic [31:0] rem_nxt;
  logic [25:0] quo_nxt;
  always_comb begin
    logic [32:0] trial;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < DivRadix; i++) begin
      trial = {rem_nxt, quo_nxt[QuoBits-1]};
      if (trial >= {1'b0, win_r}) begin
        trial = trial - {1'b0, win_r};
        quo_nxt = {quo_nxt[QuoBits-2:0], 1'b1};
      end else begin
        quo_nxt = {quo_nxt[QuoBits-2:0], 1'b0};
      end
      rem_nxt = trial[31:0];
    end
  end

  // Weight update.
  logic signed [16:0] mul_a;
  logic signed [19:0] rnd;
  logic signed [20:0] sum;
  logic signed [15:0] learned, new_w;
  logic signed [31:0] delta_out;
  logic signed [43:0] prod2_rnd;

  assign mul_a     = is_pre ? 17'(w_q) : (17'(weight_max_r) - 17'(w_q));
  assign prod2_rnd = prod2_r + 44'sd8388608;
  assign rnd       = 20'(prod2_rnd >>> 24);
  assign sum       = is_pre ? (21'(w_q) - 21'(rnd)) : (21'(w_q) + 21'(rnd));

  always_comb begin
    if (!learn_r) learned = w_q;
    else if (sum > 21'sd32767) learned = 16'sh7fff;
    else if (sum < -21'sd32768) learned = -16'sd32768;
    else learned = sum[15:0];
  end

  always_comb begin
    wr_w = 1'b0;
    wr_t = 1'b0;
    wr_w_data = learned;
    new_w = learned;
    delta_out = '0;
    unique case (action_r)
      ACT_PRE: begin
        wr_w = 1'b1;
        wr_t = 1'b1;
        delta_out = delta_r;
      end
      ACT_POST: wr_w = 1'b1;
      ACT_JUMP: begin
        new_w = w_q;
        delta_out = 32'(w_q);
      end
      ACT_LOAD: begin
        wr_w = 1'b1;
        wr_t = 1'b1;
        wr_w_data = load_weight_r;
        new_w = load_weight_r;
      end
      default: ;
    endcase
    if (!in_range) begin
      new_w = '0;
      delta_out = '0;
    end
    if (!(state_r == ST_FIN && (!out_valid_r || out_tready) && in_range)) begin
      wr_w = 1'b0;
      wr_t = 1'b0;
    end
  end

  // Sequencer.
  logic fin_go;
  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ST_READ;
      end
      ST_READ:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_DIV;
      ST_DIV:   if (cnt_r == 4'(DivSteps - 1)) state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_FIN;
      ST_FIN:   if (fin_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_READ: begin
        learn_r <= dt < win_sel;
        n_r     <= n_sel;
        win_r   <= win_sel;
        num_r   <= 26'(learn_rate_r) * 26'(is_pre ? dep_step_r : pot_step_r);
        delta_r <= 32'((dprod + 34'sd2048) >>> 12);
      end
      ST_MUL: begin
        rem_r <= prod[57:26];
        quo_r <= prod[25:0];
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 4'd1;
      end
      ST_APPLY: prod2_r <= 44'(mul_a) * $signed({18'd0, quo_r});
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) out_data_r <= {new_w, delta_out};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
